/* src/dual_line_edge_counter_reporter_macros.svh */
// Assertion macros for the dual line edge counter reporter.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef DUAL_LINE_EDGE_COUNTER_REPORTER_MACROS_SVH
`define DUAL_LINE_EDGE_COUNTER_REPORTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DLECR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DLECR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/dlecr_pkg.sv */
// Shared types, codes and helpers for the dual line edge counter reporter.
// No dependencies.
package dlecr_pkg;

  typedef enum logic [1:0] {
    CMD_FAST_TICK   = 2'd0,
    CMD_SECOND_TICK = 2'd1,
    CMD_PACKET      = 2'd2,
    CMD_STARTUP     = 2'd3
  } cmd_t;

  localparam logic [7:0] DIVIDER_RESET = 8'd40;
  localparam logic [7:0] LAST_SEQ_RESET = 8'hFF;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_Q = 8'h51;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam logic [7:0] LETTER_BASE = 8'd55;
  localparam int REPORT_LEN = 28;
  localparam logic [4:0] LAST_POS = 5'(REPORT_LEN - 1);
  localparam logic [4:0] SEP_POS_A = 5'd1;
  localparam logic [4:0] SEP_POS_B = 5'd10;
  localparam logic [4:0] SEP_POS_C = 5'd19;

  // Snapshot of counters taken when a report is requested.
  typedef struct packed {
    logic [31:0] count_a;
    logic [31:0] count_b;
    logic [31:0] elapsed;
    logic [7:0]  seq;
  } snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] v;
    v = {4'd0, nib};
    return (nib <= 4'd9) ? (v + DIGIT_BASE) : (v + LETTER_BASE);
  endfunction

endpackage

/* src/dual_line_edge_counter_reporter.sv */
// Dual line edge counter reporter, top level. The front end updates its counters as commands
// are accepted; a report leaves the back end as 28 bytes, one per cycle while out_ready is
// high, after its snapshot passes through the queue, so the output port sets the sustained rate.
// Input stalls only while the snapshot queue (QUEUE_DEPTH entries) is full.
// Synchronous active-low reset: counters clear, a report is pending, divider is 40.
module dual_line_edge_counter_reporter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic        in_line_a,
  input  logic        in_line_b,
  input  logic [31:0] in_rx_source,
  input  logic [7:0]  in_rx_seq,
  input  logic [7:0]  in_rx_first_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_report_char,
  output logic [7:0]  out_report_number,
  output logic        out_last_char,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dlecr_pkg::*;

  `include "dual_line_edge_counter_reporter_macros.svh"

  logic [7:0] divider_r;
  q_stat_t    q_stat;
  snap_t      q_wdata, q_rdata;
  logic       q_push, q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {24'd0, divider_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_r <= DIVIDER_RESET;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      divider_r <= pwdata[7:0];
    end
  end

  dlecr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_line_a, .in_line_b,
    .in_rx_source, .in_rx_seq, .in_rx_first_char,
    .sample_divider(divider_r), .q_stat, .q_push, .q_wdata
  );

  dlecr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .pop(q_pop), .rdata(q_rdata),
    .stat(q_stat)
  );

  dlecr_back u_back (
    .clk, .rst_n, .q_stat, .q_rdata, .q_pop, .out_valid, .out_ready,
    .out_report_char, .out_report_number, .out_last_char
  );

  `DLECR_ASSERT_SAME(a_no_overflow, q_push, !q_stat.full, "push into full report queue")
  `DLECR_ASSERT_SAME(a_no_underflow, q_pop, !q_stat.empty, "pop from empty report queue")
  `DLECR_ASSERT_NEXT(a_report_starts_c, out_valid && out_ready && out_last_char, !out_valid || out_report_char == CHAR_C, "report does not start with C")
  `DLECR_ASSERT_NEXT(a_startup_queued, in_valid && in_ready && in_cmd == CMD_STARTUP, !q_stat.empty, "start-up report not queued")

endmodule

/* src/dlecr_front.sv */
// Front end: accepts commands, keeps counters and packet history, queues reports.
// Depends on dlecr_pkg.
module dlecr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic              in_line_a,
  input  logic              in_line_b,
  input  logic [31:0]       in_rx_source,
  input  logic [7:0]        in_rx_seq,
  input  logic [7:0]        in_rx_first_char,
  input  logic [7:0]        sample_divider,
  input  dlecr_pkg::q_stat_t q_stat,
  output logic              q_push,
  output dlecr_pkg::snap_t  q_wdata
);
  import dlecr_pkg::*;

  logic [7:0]  tick_r, tick_nxt;
  logic [1:0]  prev_r, prev_nxt;
  logic [31:0] cnt_a_r, cnt_a_nxt;
  logic [31:0] cnt_b_r, cnt_b_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic        pending_r, pending_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [31:0] last_src_r, last_src_nxt;
  logic [7:0]  last_seq_r, last_seq_nxt;

  logic        acc;
  logic [8:0]  tick_sum;
  logic        fall_a, fall_b;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign tick_sum = {1'b0, tick_r} + 9'd1;
  assign fall_a   = prev_r[0] && !in_line_a;
  assign fall_b   = prev_r[1] && !in_line_b;

  always_comb begin
    tick_nxt     = tick_r;
    prev_nxt     = prev_r;
    cnt_a_nxt    = cnt_a_r;
    cnt_b_nxt    = cnt_b_r;
    elapsed_nxt  = elapsed_r;
    pending_nxt  = pending_r;
    seq_nxt      = seq_r;
    last_src_nxt = last_src_r;
    last_seq_nxt = last_seq_r;
    q_push       = 1'b0;
    if (acc) begin
      unique case (cmd_t'(in_cmd))
        CMD_STARTUP: begin
          q_push  = 1'b1;
          seq_nxt = seq_r + 8'd1;
        end
        CMD_SECOND_TICK: begin
          elapsed_nxt = elapsed_r + 32'd1;
        end
        CMD_PACKET: begin
          if (!(in_rx_source == last_src_r && in_rx_seq == last_seq_r)) begin
            if (in_rx_first_char == CHAR_R) begin
              cnt_a_nxt   = '0;
              cnt_b_nxt   = '0;
              elapsed_nxt = '0;
              pending_nxt = 1'b1;
            end else if (in_rx_first_char == CHAR_Q) begin
              pending_nxt = 1'b1;
            end
            last_src_nxt = in_rx_source;
            last_seq_nxt = in_rx_seq;
          end
        end
        CMD_FAST_TICK: begin
          if (tick_sum <= {1'b0, sample_divider}) begin
            tick_nxt = tick_sum[7:0];
          end else begin
            tick_nxt = '0;
            prev_nxt = {in_line_b, in_line_a};
            if (fall_a) cnt_a_nxt = cnt_a_r + 32'd1;
            if (fall_b) cnt_b_nxt = cnt_b_r + 32'd1;
            if (pending_r || fall_a || fall_b) begin
              q_push      = 1'b1;
              pending_nxt = 1'b0;
              seq_nxt     = seq_r + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign q_wdata = '{count_a: cnt_a_nxt, count_b: cnt_b_nxt, elapsed: elapsed_nxt,
                     seq: seq_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      prev_r     <= '0;
      cnt_a_r    <= '0;
      cnt_b_r    <= '0;
      elapsed_r  <= '0;
      pending_r  <= 1'b1;
      seq_r      <= '0;
      last_src_r <= '0;
      last_seq_r <= LAST_SEQ_RESET;
    end else begin
      tick_r     <= tick_nxt;
      prev_r     <= prev_nxt;
      cnt_a_r    <= cnt_a_nxt;
      cnt_b_r    <= cnt_b_nxt;
      elapsed_r  <= elapsed_nxt;
      pending_r  <= pending_nxt;
      seq_r      <= seq_nxt;
      last_src_r <= last_src_nxt;
      last_seq_r <= last_seq_nxt;
    end
  end

endmodule

/* src/dlecr_queue.sv */
// Small register FIFO of report snapshots between front and back.
// Depends on dlecr_pkg.
module dlecr_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dlecr_pkg::snap_t   wdata,
  input  logic               pop,
  output dlecr_pkg::snap_t   rdata,
  output dlecr_pkg::q_stat_t stat
);
  import dlecr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  snap_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

/* src/dlecr_back.sv */
// Back end: turns queued snapshots into 28-byte ASCII reports, one byte per cycle unless out_ready stalls.
// Depends on dlecr_pkg.
module dlecr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dlecr_pkg::q_stat_t q_stat,
  input  dlecr_pkg::snap_t   q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_report_char,
  output logic [7:0]         out_report_number,
  output logic               out_last_char
);
  import dlecr_pkg::*;

  logic        active_r;
  logic [4:0]  pos_r;
  logic [95:0] shift_r;
  logic [7:0]  seq_r;
  logic        valid_r;
  logic [7:0]  char_r, num_r;
  logic        last_r;
  logic        adv, is_sep;

  assign adv    = !valid_r || out_ready;
  assign q_pop  = adv && !active_r && !q_stat.empty;
  assign is_sep = (pos_r == SEP_POS_A) || (pos_r == SEP_POS_B) || (pos_r == SEP_POS_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= '0;
      valid_r  <= 1'b0;
    end else if (adv) begin
      if (active_r) begin
        valid_r <= 1'b1;
        char_r  <= is_sep ? CHAR_COLON : hex_char(shift_r[95:92]);
        num_r   <= seq_r;
        last_r  <= (pos_r == LAST_POS);
        if (!is_sep) shift_r <= {shift_r[91:0], 4'd0};
        if (pos_r == LAST_POS) active_r <= 1'b0;
        pos_r <= pos_r + 5'd1;
      end else if (!q_stat.empty) begin
        // Load snapshot and emit the leading 'C' at once.
        active_r <= 1'b1;
        pos_r    <= 5'd1;
        shift_r  <= {q_rdata.count_a, q_rdata.count_b, q_rdata.elapsed};
        seq_r    <= q_rdata.seq;
        valid_r  <= 1'b1;
        char_r   <= CHAR_C;
        num_r    <= q_rdata.seq;
        last_r   <= 1'b0;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = valid_r;
  assign out_report_char   = char_r;
  assign out_report_number = num_r;
  assign out_last_char     = last_r;

endmodule

/* tb/dual_line_edge_counter_reporter_tb.sv */
// Self-checking testbench for dual_line_edge_counter_reporter: request stimulus,
// APB divider writes and a scoreboard of expected report bytes.
// Depends on dlecr_pkg and the dual_line_edge_counter_reporter top level.
`timescale 1ns / 100ps

module dual_line_edge_counter_reporter_tb;
  import dlecr_pkg::*;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [0:0]  DIVIDER_ADDR = 1'b0;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] num;
    logic       last;
  } rpt_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic        in_line_a;
  logic        in_line_b;
  logic [31:0] in_rx_source;
  logic [7:0]  in_rx_seq;
  logic [7:0]  in_rx_first_char;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_report_char;
  logic [7:0]  out_report_number;
  logic        out_last_char;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the block state
  logic [7:0]  div_m;
  logic [7:0]  ticks_m;
  logic [1:0]  levels_m;
  logic [31:0] edges_a_m;
  logic [31:0] edges_b_m;
  logic [31:0] seconds_m;
  logic        pending_m;
  logic [7:0]  rpt_seq_m;
  logic [31:0] last_src_m;
  logic [7:0]  last_seq_m;

  rpt_byte_t expected_bytes[$];

  int  fail_count    = 0;
  int  mismatch_count = 0;
  int  requests_sent = 0;
  int  reports_queued = 0;
  int  bytes_checked = 0;
  int  stall_cycles  = 0;
  int  hold_cycles   = 0;
  int  rx_gap        = 0;
  bit  idle_on       = 1'b1;

  dual_line_edge_counter_reporter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_line_a        (in_line_a),
    .in_line_b        (in_line_b),
    .in_rx_source     (in_rx_source),
    .in_rx_seq        (in_rx_seq),
    .in_rx_first_char (in_rx_first_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_report_char  (out_report_char),
    .out_report_number(out_report_number),
    .out_last_char    (out_last_char),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h41 + 8'(n) - 8'd10);
  endfunction

  // Build the 28 report bytes from the current counters
  task automatic queue_report();
    logic [7:0] text [REPORT_LEN];
    rpt_byte_t  b;
    rpt_seq_m = rpt_seq_m + 8'd1;
    text[0]  = CHAR_C;
    text[1]  = CHAR_COLON;
    text[10] = CHAR_COLON;
    text[19] = CHAR_COLON;
    for (int k = 0; k < 8; k++) begin
      text[2 + k]  = nibble_ascii(edges_a_m[31 - 4 * k -: 4]);
      text[11 + k] = nibble_ascii(edges_b_m[31 - 4 * k -: 4]);
      text[20 + k] = nibble_ascii(seconds_m[31 - 4 * k -: 4]);
    end
    for (int k = 0; k < REPORT_LEN; k++) begin
      b.ch   = text[k];
      b.num  = rpt_seq_m;
      b.last = (k == REPORT_LEN - 1);
      expected_bytes.push_back(b);
    end
    reports_queued++;
  endtask

  task automatic predict_request(input cmd_t cmd, input logic a, input logic b,
                                 input logic [31:0] src, input logic [7:0] seq,
                                 input logic [7:0] ch);
    logic [8:0] nxt;
    logic [1:0] now;
    case (cmd)
      CMD_STARTUP: begin
        queue_report();
      end
      CMD_SECOND_TICK: begin
        seconds_m = seconds_m + 32'd1;
      end
      CMD_PACKET: begin
        if (!(src == last_src_m && seq == last_seq_m)) begin
          if (ch == CHAR_R) begin
            edges_a_m = '0;
            edges_b_m = '0;
            seconds_m = '0;
            pending_m = 1'b1;
          end else if (ch == CHAR_Q) begin
            pending_m = 1'b1;
          end
          last_src_m = src;
          last_seq_m = seq;
        end
      end
      default: begin
        nxt = {1'b0, ticks_m} + 9'd1;
        if (nxt <= {1'b0, div_m}) begin
          ticks_m = nxt[7:0];
        end else begin
          ticks_m = '0;
          now = {b, a};
          if (levels_m[0] && !now[0]) begin
            edges_a_m = edges_a_m + 32'd1;
            pending_m = 1'b1;
          end
          if (levels_m[1] && !now[1]) begin
            edges_b_m = edges_b_m + 32'd1;
            pending_m = 1'b1;
          end
          levels_m = now;
          if (pending_m) begin
            pending_m = 1'b0;
            queue_report();
          end
        end
      end
    endcase
  endtask

  task automatic send_item(input cmd_t cmd, input logic a, input logic b,
                           input logic [31:0] src, input logic [7:0] seq,
                           input logic [7:0] ch);
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_line_a        <= a;
    in_line_b        <= b;
    in_rx_source     <= src;
    in_rx_seq        <= seq;
    in_rx_first_char <= ch;
    do @(posedge clk); while (!in_ready);
    predict_request(cmd, a, b, src, seq, ch);
    requests_sent++;
  endtask

  // Drop valid, wait for every expected byte, then let the front end go quiet
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_divider(input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIVIDER_ADDR;
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    div_m = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_random();
    int          pick;
    cmd_t        cmd;
    logic [31:0] src;
    logic [7:0]  seq;
    logic [7:0]  ch;
    pick = $urandom_range(0, 99);
    src  = $urandom;
    seq  = 8'($urandom_range(0, 255));
    ch   = 8'($urandom_range(0, 255));
    if (pick < 55)      cmd = CMD_FAST_TICK;
    else if (pick < 67) cmd = CMD_SECOND_TICK;
    else if (pick < 92) cmd = CMD_PACKET;
    else                cmd = CMD_STARTUP;
    if (cmd == CMD_PACKET) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        src = last_src_m;
        seq = last_seq_m;
      end else if (pick == 3) begin
        src = '0;
      end else if (pick == 4) begin
        src = '1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 2)      ch = CHAR_R;
      else if (pick < 5) ch = CHAR_Q;
    end
    send_item(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), src, seq, ch);
  endtask

  // Reset divider is 40; shrink it below the tick count so the next tick samples
  task automatic test_divider_shrink();
    repeat (5) send_item(CMD_FAST_TICK, 1'b1, 1'b1, '0, '0, '0);
    settle_block();
    write_divider(8'd2);
    send_item(CMD_FAST_TICK, 1'b1, 1'b1, '0, '0, '0);
    settle_block();
  endtask

  task automatic test_divider_zero();
    write_divider(8'd0);
    send_item(CMD_FAST_TICK, 1'b0, 1'b0, '0, '0, '0);
    send_item(CMD_FAST_TICK, 1'b1, 1'b0, '0, '0, '0);
    send_item(CMD_FAST_TICK, 1'b0, 1'b1, '0, '0, '0);
    send_item(CMD_FAST_TICK, 1'b1, 1'b1, '0, '0, '0);
    send_item(CMD_FAST_TICK, 1'b0, 1'b0, '0, '0, '0);
    send_item(CMD_FAST_TICK, 1'b0, 1'b0, '0, '0, '0);
    settle_block();
  endtask

  task automatic test_packets();
    // Matches the remembered source and sequence from reset: ignore
    send_item(CMD_PACKET, 1'b1, 1'b1, 32'd0, LAST_SEQ_RESET, CHAR_R);
    send_item(CMD_SECOND_TICK, 1'b1, 1'b1, '1, '1, '1);
    send_item(CMD_PACKET, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'd0, CHAR_Q);
    send_item(CMD_PACKET, 1'b0, 1'b0, 32'hFFFF_FFFF, 8'd0, CHAR_R);
    send_item(CMD_FAST_TICK, 1'b1, 1'b1, '1, '1, '1);
    send_item(CMD_PACKET, 1'b1, 1'b0, 32'h1234_5678, 8'd7, CHAR_R);
    send_item(CMD_PACKET, 1'b0, 1'b1, 32'h1234_5678, 8'd8, 8'h58);
    send_item(CMD_PACKET, 1'b0, 1'b0, 32'h0000_0001, 8'd8, 8'd0);
    send_item(CMD_SECOND_TICK, 1'b0, 1'b0, '0, '0, '0);
    send_item(CMD_FAST_TICK, 1'b0, 1'b0, '0, '0, '0);
    settle_block();
  endtask

  // A start-up report leaves a pending request for the next sample tick
  task automatic test_startup();
    send_item(CMD_PACKET, 1'b0, 1'b0, 32'h8000_0000, 8'hAA, CHAR_Q);
    send_item(CMD_STARTUP, 1'b1, 1'b1, '1, '1, '1);
    send_item(CMD_FAST_TICK, 1'b0, 1'b0, '0, '0, '0);
    settle_block();
  endtask

  task automatic test_divider_max();
    write_divider(8'd255);
    repeat (4) send_item(CMD_FAST_TICK, 1'b1, 1'b1, '0, '0, '0);
    settle_block();
    write_divider(8'd1);
    send_item(CMD_FAST_TICK, 1'b0, 1'b1, '0, '0, '0);
    send_item(CMD_FAST_TICK, 1'b0, 1'b0, '0, '0, '0);
    settle_block();
  endtask

  // Hold the receiver off while start-up requests pile up behind the queue
  task automatic test_backpressure();
    idle_on     = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (6) send_item(CMD_STARTUP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
    idle_on = 1'b1;
    settle_block();
  endtask

  task automatic test_random_traffic();
    logic [7:0] dividers [5] = '{8'd0, 8'd1, 8'd3, 8'd0, 8'd2};
    foreach (dividers[i]) begin
      write_divider(dividers[i]);
      repeat (42) send_random();
      settle_block();
    end
  endtask

  task automatic test_seq_wrap();
    do begin
      send_item(CMD_STARTUP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                $urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end while (rpt_seq_m != 8'd0);
    send_item(CMD_STARTUP, 1'b0, 1'b0, '0, '0, '0);
    settle_block();
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    write_divider(8'd0);
    repeat (40) send_random();
    settle_block();
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap = rx_gap - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      rx_gap = $urandom_range(1, 9) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rpt_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected report byte: char %h num %h last %b",
                   out_report_char, out_report_number, out_last_char);
      end else begin
        want = expected_bytes.pop_front();
        if (out_report_char !== want.ch || out_report_number !== want.num ||
            out_last_char !== want.last) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("report byte mismatch: expected char %h num %h last %b, got %h %h %b",
                     want.ch, want.num, want.last,
                     out_report_char, out_report_number, out_last_char);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = CMD_FAST_TICK;
    in_line_a        = 1'b0;
    in_line_b        = 1'b0;
    in_rx_source     = '0;
    in_rx_seq        = '0;
    in_rx_first_char = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = DIVIDER_ADDR;
    pwdata           = '0;
    div_m            = DIVIDER_RESET;
    ticks_m          = '0;
    levels_m         = '0;
    edges_a_m        = '0;
    edges_b_m        = '0;
    seconds_m        = '0;
    pending_m        = 1'b1;
    rpt_seq_m        = '0;
    last_src_m       = '0;
    last_seq_m       = LAST_SEQ_RESET;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_divider_shrink();
    test_divider_zero();
    test_packets();
    test_startup();
    test_divider_max();
    test_backpressure();
    test_random_traffic();
    test_seq_wrap();
    test_streaming();

    if (expected_bytes.size() != 0) fail_count++;
    $display("Sent %0d requests across divider settings 0 to 255; %0d reports queued,",
             requests_sent, reports_queued);
    $display("%0d report bytes checked, %0d mismatches", bytes_checked, mismatch_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/dlecr_pkg.sv
src/dlecr_front.sv
src/dlecr_queue.sv
src/dlecr_back.sv
src/dual_line_edge_counter_reporter.sv
tb/dual_line_edge_counter_reporter_tb.sv
